// ----- sv/two_electrode_touch_slider_macros.svh -----
// Assertion helpers for the touch slider. Both sample on the rising edge of clk
// and stay quiet while rst_n is low.
`ifndef TWO_ELECTRODE_TOUCH_SLIDER_MACROS_SVH
`define TWO_ELECTRODE_TOUCH_SLIDER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TES_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TES_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/tes_pkg.sv -----
package tes_pkg;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_DONE
  } state_t;

  // Request commands.
  localparam logic [1:0] CMD_SCAN = 2'd0;
  localparam logic [1:0] CMD_BASE = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_THR_FIRST = 2'd0;
  localparam logic [1:0] REG_THR_SECOND = 2'd1;
  localparam logic [1:0] REG_CH_FIRST = 2'd2;
  localparam logic [1:0] REG_CH_SECOND = 2'd3;

  // Field and datapath widths.
  localparam int COUNT_BITS_DEF = 16;
  localparam int FIELD_W = 16;
  localparam int DIFF_W = 16;
  localparam int DELTA_W = 15;
  localparam int THR_W = 16;
  localparam int CHAN_W = 4;
  localparam int POS_W = 7;
  localparam int QUO_W = 7;
  localparam int STEP_W = 3;
  localparam int NUM_W = 22;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUO_W - 1);
  localparam logic [POS_W-1:0] POS_SCALE = 7'd100;

  // Register reset values.
  localparam logic [THR_W-1:0] THR_RESET = 16'd100;
  localparam logic [CHAN_W-1:0] CH_FIRST_RESET = 4'd9;
  localparam logic [CHAN_W-1:0] CH_SECOND_RESET = 4'd8;

  // Delta times 100 as a sum of three shifted copies.
  function automatic logic [NUM_W-1:0] scale_delta(logic [DELTA_W-1:0] d);
    logic [NUM_W-1:0] w;
    w = NUM_W'(d);
    return (w << 6) + (w << 5) + (w << 2);
  endfunction

  // Position (100 - a + b) / 2 from the two quotients.
  function automatic logic [POS_W-1:0] pos_calc(logic [QUO_W-1:0] a, logic [QUO_W-1:0] b);
    logic [POS_W:0] t;
    t = {1'b0, POS_SCALE} - {1'b0, a} + {1'b0, b};
    return t[POS_W:1];
  endfunction

endpackage

// ----- sv/two_electrode_touch_slider.sv -----
// Two-electrode capacitive slider. Scan requests (tuser cmd 0) subtract the
// stored baseline from the count of the electrode under the round-robin pointer,
// clamp negative results to zero and step the pointer; baseline requests (cmd 1)
// store a count for the electrode in tuser bit 2 and point the scan back at
// electrode 0; read requests (cmd 2) return the slider position 0..100 once per
// finished scan, or 0. Every request gives exactly one result carrying the
// channel to scan next. Scan, baseline, stale or untouched read requests pass
// through the EXEC and DONE states into the output register, and the block takes
// no new request until then; a touched read also runs through the DIV state,
// because one shared 23-bit subtractor runs a 7-step restoring division for each
// electrode's share of the total delta, one quotient bit per cycle. DONE waits
// while the output register holds an untaken result. The input side is ready
// again as soon as the result sits in the output register.
`include "two_electrode_touch_slider_macros.svh"

module two_electrode_touch_slider #(
  parameter int COUNT_BITS = tes_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [15:0] sense_count
  input  logic [tes_pkg::FIELD_W-1:0] in_tdata,
  // [1:0] cmd, [2] electrode_sel
  input  logic [2:0]                  in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [6:0] slider_position, [10:7] next_channel, [15:11] zero
  output logic [15:0]                 out_tdata,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [tes_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [tes_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [tes_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int NUM_W = tes_pkg::NUM_W;
  localparam int DELTA_W = tes_pkg::DELTA_W;
  localparam int QUO_W = tes_pkg::QUO_W;
  localparam int POS_W = tes_pkg::POS_W;
  localparam int CHAN_W = tes_pkg::CHAN_W;
  localparam int THR_W = tes_pkg::THR_W;

  tes_pkg::state_t state_r, state_nxt;

  logic [1:0]                cmd_r, cmd_nxt;
  logic [COUNT_BITS-1:0]     count_r, count_nxt;
  logic                      sel_r, sel_nxt;
  logic [COUNT_BITS-1:0]     base_r [2];
  logic [COUNT_BITS-1:0]     base_nxt [2];
  logic [DELTA_W-1:0]        delta_r [2];
  logic [DELTA_W-1:0]        delta_nxt [2];
  logic                      ptr_r, ptr_nxt;
  logic                      fresh_r, fresh_nxt;
  logic [NUM_W-1:0]          num_r, num_nxt;
  logic [QUO_W-1:0]          q_r, q_nxt;
  logic [QUO_W-1:0]          a_r, a_nxt;
  logic [tes_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                      div_sel_r, div_sel_nxt;
  logic [POS_W-1:0]          pos_r, pos_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]          out_pos_r, out_pos_nxt;
  logic [CHAN_W-1:0]         out_chan_r, out_chan_nxt;
  logic [THR_W-1:0]          thr0_r, thr1_r;
  logic [CHAN_W-1:0]         ch0_r, ch1_r;

  logic                      in_acc;
  logic                      out_free;
  logic                      touch;
  logic [DELTA_W:0]          sum_w;
  logic [NUM_W-1:0]          sub_a, sub_b;
  logic [NUM_W:0]            sub_res;
  logic                      borrow;
  logic [tes_pkg::DIFF_W-1:0] diff;
  logic [QUO_W-1:0]          q_cur;
  logic                      cfg_we;

  assign in_tready = (state_r == tes_pkg::ST_IDLE);
  assign in_acc = in_tvalid & in_tready;
  assign out_free = ~out_valid_r | out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata = {5'd0, out_chan_r, out_pos_r};
  assign cfg_pready = 1'b1;
  assign cfg_we = cfg_psel & cfg_penable & cfg_pwrite;

  // Touch test and total delta, the divisor of both divisions.
  assign touch = ({1'b0, delta_r[0]} > thr0_r) | ({1'b0, delta_r[1]} > thr1_r);
  assign sum_w = {1'b0, delta_r[0]} + {1'b0, delta_r[1]};

  // Shared subtractor: division steps while dividing, baseline difference otherwise.
  always_comb begin
    if (state_r == tes_pkg::ST_DIV) begin
      sub_a = num_r;
      sub_b = NUM_W'(sum_w) << step_r;
    end else begin
      sub_a = NUM_W'(count_r);
      sub_b = NUM_W'(base_r[ptr_r]);
    end
    sub_res = {1'b0, sub_a} - {1'b0, sub_b};
  end

  assign borrow = sub_res[NUM_W];
  assign diff = sub_res[tes_pkg::DIFF_W-1:0];
  assign q_cur = borrow ? q_r : (q_r | (QUO_W'(1) << step_r));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tes_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = tes_pkg::ST_EXEC;
      end
      tes_pkg::ST_EXEC: begin
        if (cmd_r == tes_pkg::CMD_READ && fresh_r && touch) state_nxt = tes_pkg::ST_DIV;
        else state_nxt = tes_pkg::ST_DONE;
      end
      tes_pkg::ST_DIV: begin
        if (step_r == '0 && div_sel_r) state_nxt = tes_pkg::ST_DONE;
      end
      tes_pkg::ST_DONE: begin
        if (out_free) state_nxt = tes_pkg::ST_IDLE;
      end
      default: state_nxt = tes_pkg::ST_IDLE;
    endcase
  end

  // Datapath and result register.
  always_comb begin
    cmd_nxt = cmd_r;
    count_nxt = count_r;
    sel_nxt = sel_r;
    base_nxt = base_r;
    delta_nxt = delta_r;
    ptr_nxt = ptr_r;
    fresh_nxt = fresh_r;
    num_nxt = num_r;
    q_nxt = q_r;
    a_nxt = a_r;
    step_nxt = step_r;
    div_sel_nxt = div_sel_r;
    pos_nxt = pos_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_pos_nxt = out_pos_r;
    out_chan_nxt = out_chan_r;
    case (state_r)
      tes_pkg::ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt = in_tuser[1:0];
          count_nxt = in_tdata[COUNT_BITS-1:0];
          sel_nxt = in_tuser[2];
        end
      end
      tes_pkg::ST_EXEC: begin
        pos_nxt = '0;
        case (cmd_r)
          tes_pkg::CMD_SCAN: begin
            // A difference with the sign bit set clamps to zero.
            delta_nxt[ptr_r] = diff[tes_pkg::DIFF_W-1] ? '0 : diff[DELTA_W-1:0];
            ptr_nxt = ~ptr_r;
            fresh_nxt = 1'b1;
          end
          tes_pkg::CMD_BASE: begin
            base_nxt[sel_r] = count_r;
            ptr_nxt = 1'b0;
          end
          tes_pkg::CMD_READ: begin
            if (fresh_r) begin
              fresh_nxt = 1'b0;
              num_nxt = tes_pkg::scale_delta(delta_r[0]);
              q_nxt = '0;
              step_nxt = tes_pkg::STEP_LAST;
              div_sel_nxt = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      tes_pkg::ST_DIV: begin
        // One restoring step: keep the remainder when the shifted divisor fits.
        if (!borrow) num_nxt = sub_res[NUM_W-1:0];
        q_nxt = q_cur;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          if (!div_sel_r) begin
            a_nxt = q_cur;
            num_nxt = tes_pkg::scale_delta(delta_r[1]);
            q_nxt = '0;
            step_nxt = tes_pkg::STEP_LAST;
            div_sel_nxt = 1'b1;
          end else begin
            pos_nxt = tes_pkg::pos_calc(a_r, q_cur);
          end
        end
      end
      tes_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt = pos_r;
          out_chan_nxt = ptr_r ? ch1_r : ch0_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Register read-back.
  always_comb begin
    case (cfg_paddr[3:2])
      tes_pkg::REG_THR_FIRST:  cfg_prdata = 32'(thr0_r);
      tes_pkg::REG_THR_SECOND: cfg_prdata = 32'(thr1_r);
      tes_pkg::REG_CH_FIRST:   cfg_prdata = 32'(ch0_r);
      tes_pkg::REG_CH_SECOND:  cfg_prdata = 32'(ch1_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr0_r <= tes_pkg::THR_RESET;
      thr1_r <= tes_pkg::THR_RESET;
      ch0_r <= tes_pkg::CH_FIRST_RESET;
      ch1_r <= tes_pkg::CH_SECOND_RESET;
    end else if (cfg_we) begin
      case (cfg_paddr[3:2])
        tes_pkg::REG_THR_FIRST:  thr0_r <= cfg_pwdata[THR_W-1:0];
        tes_pkg::REG_THR_SECOND: thr1_r <= cfg_pwdata[THR_W-1:0];
        tes_pkg::REG_CH_FIRST:   ch0_r <= cfg_pwdata[CHAN_W-1:0];
        tes_pkg::REG_CH_SECOND:  ch1_r <= cfg_pwdata[CHAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tes_pkg::ST_IDLE;
      base_r[0] <= '0;
      base_r[1] <= '0;
      delta_r[0] <= '0;
      delta_r[1] <= '0;
      ptr_r <= 1'b0;
      fresh_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      base_r <= base_nxt;
      delta_r <= delta_nxt;
      ptr_r <= ptr_nxt;
      fresh_r <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    count_r <= count_nxt;
    sel_r <= sel_nxt;
    num_r <= num_nxt;
    q_r <= q_nxt;
    a_r <= a_nxt;
    step_r <= step_nxt;
    div_sel_r <= div_sel_nxt;
    pos_r <= pos_nxt;
    out_pos_r <= out_pos_nxt;
    out_chan_r <= out_chan_nxt;
  end

  `TES_ASSERT_NXT(a_busy_after_accept, in_acc, !in_tready, "request accepted while busy")
  `TES_ASSERT_IMP(a_div_only_consumed, state_r == tes_pkg::ST_DIV, !fresh_r, "dividing with fresh mark set")
  `TES_ASSERT_IMP(a_pos_range, out_tvalid, out_tdata[6:0] <= 7'd100, "slider position above 100")
  `TES_ASSERT_NXT(a_scan_marks_fresh, state_r == tes_pkg::ST_EXEC && cmd_r == tes_pkg::CMD_SCAN, fresh_r, "scan did not mark fresh data")

endmodule
